// ----- rtl/csdb_pkg.sv -----
`default_nettype none

package csdb_pkg;

   // Sizes of the clip stack and the coordinate words.
   localparam int STACK_DEPTH = 8;
   localparam int COORD_BITS  = 16;

   localparam int LEVEL_BITS = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_BITS  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam int SIZE_BITS     = COORD_BITS - 1;
   localparam int IMAGE_BITS    = 16;
   localparam int COUNT_BITS    = 16;
   localparam int CNT_BITS      = 24;
   localparam int TYPE_BITS     = 3;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

   // Result queue depth; two entries must be free before a command retires.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   // Viewport reset values.
   localparam logic signed [COORD_BITS-1:0] VIEW_XMIN_RST = COORD_BITS'(0);
   localparam logic signed [COORD_BITS-1:0] VIEW_YMIN_RST = COORD_BITS'(0);
   localparam logic signed [COORD_BITS-1:0] VIEW_XMAX_RST = COORD_BITS'(1920);
   localparam logic signed [COORD_BITS-1:0] VIEW_YMAX_RST = COORD_BITS'(1080);
   localparam logic [IMAGE_BITS-1:0] WHITE_IMAGE_RST = IMAGE_BITS'(0);
   localparam logic [IMAGE_BITS-1:0] FONT_IMAGE_RST  = IMAGE_BITS'(1);

   typedef enum logic [TYPE_BITS-1:0] {
      CMD_TEXT       = 3'd0,
      CMD_RECT       = 3'd1,
      CMD_IMAGE      = 3'd2,
      CMD_CLIP_START = 3'd3,
      CMD_CLIP_END   = 3'd4
   } cmd_type_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_VIEW_XMIN   = 3'd0,
      REG_VIEW_YMIN   = 3'd1,
      REG_VIEW_XMAX   = 3'd2,
      REG_VIEW_YMAX   = 3'd3,
      REG_WHITE_IMAGE = 3'd4,
      REG_FONT_IMAGE  = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] xmin;
      logic signed [COORD_BITS-1:0] ymin;
      logic signed [COORD_BITS-1:0] xmax;
      logic signed [COORD_BITS-1:0] ymax;
   } rect_type;

   typedef struct packed {
      logic [CNT_BITS-1:0]   start_index;
      logic [CNT_BITS-1:0]   num_indices;
      logic                  text_pipeline;
      logic [IMAGE_BITS-1:0] batch_image;
      rect_type              scissor;
      logic                  frame_last;
   } batch_type;

   // One command held in the processing stage, with its stack access decided.
   typedef struct packed {
      logic [TYPE_BITS-1:0]         cmd;
      logic signed [COORD_BITS-1:0] box_x;
      logic signed [COORD_BITS-1:0] box_y;
      logic [SIZE_BITS-1:0]         box_w;
      logic [SIZE_BITS-1:0]         box_h;
      logic                         clip_horizontal;
      logic                         clip_vertical;
      logic                         has_image;
      logic [IMAGE_BITS-1:0]        image_id;
      logic                         image_valid;
      logic [COUNT_BITS-1:0]        index_count;
      logic                         frame_end;
      logic                         push;
      logic                         pop_ok;
      logic [ADDR_BITS-1:0]         addr;
   } stage_type;

endpackage

`default_nettype wire

// ----- rtl/clip_stack_draw_batcher.sv -----
`default_nettype none

// Commands wait in the stage register; a retiring command puts its batches in the result queue.
// Throughput: one command per cycle while the result queue has two free entries; a command
// that closes one batch and flushes another needs two rsp_ transactions to drain.
// Reset clears control state, the result queue and loads the viewport and image registers;
// the clip stack memory is not cleared and only entries pushed in the current frame are read.
module clip_stack_draw_batcher (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // configuration
   input  wire logic                                   csr_write,
   input  wire logic [csdb_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire logic [csdb_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   // commands
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic [csdb_pkg::TYPE_BITS-1:0]         req_type,
   input  wire logic signed [csdb_pkg::COORD_BITS-1:0] req_box_x,
   input  wire logic signed [csdb_pkg::COORD_BITS-1:0] req_box_y,
   input  wire logic [csdb_pkg::SIZE_BITS-1:0]         req_box_w,
   input  wire logic [csdb_pkg::SIZE_BITS-1:0]         req_box_h,
   input  wire logic                                   req_clip_horizontal,
   input  wire logic                                   req_clip_vertical,
   input  wire logic                                   req_has_image,
   input  wire logic [csdb_pkg::IMAGE_BITS-1:0]        req_image_id,
   input  wire logic                                   req_image_valid,
   input  wire logic [csdb_pkg::COUNT_BITS-1:0]        req_index_count,
   input  wire logic                                   req_frame_end,
   // batches
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic [csdb_pkg::CNT_BITS-1:0]          rsp_start_index,
   output      logic [csdb_pkg::CNT_BITS-1:0]          rsp_num_indices,
   output      logic                                   rsp_text_pipeline,
   output      logic [csdb_pkg::IMAGE_BITS-1:0]        rsp_batch_image,
   output      logic signed [csdb_pkg::COORD_BITS-1:0] rsp_sc_xmin,
   output      logic signed [csdb_pkg::COORD_BITS-1:0] rsp_sc_ymin,
   output      logic signed [csdb_pkg::COORD_BITS-1:0] rsp_sc_xmax,
   output      logic signed [csdb_pkg::COORD_BITS-1:0] rsp_sc_ymax,
   output      logic                                   rsp_frame_last
);
   import csdb_pkg::*;

   // Configuration registers.
   rect_type              view_ff;
   logic [IMAGE_BITS-1:0] white_image_ff;
   logic [IMAGE_BITS-1:0] font_image_ff;

   // Stack level, tracked at accept time so the memory read can be issued then.
   logic [LEVEL_BITS-1:0] level_ff, level_in;

   // Processing stage.
   logic      s2_valid_ff, s2_valid_in;
   stage_type s2_ff, s2_in;
   logic      s2_fire;
   logic      accept;

   // Clip stack memory and its registered read port.
   rect_type             stack_mem [STACK_DEPTH];
   rect_type             rd_data_ff;
   logic [ADDR_BITS-1:0] rd_addr;

   // Batcher state.
   rect_type              cur_ff, cur_in;
   logic                  fresh_ff, fresh_in;
   logic                  open_valid_ff, open_valid_in;
   logic [1:0]            open_type_ff, open_type_in;
   logic [IMAGE_BITS-1:0] open_image_ff, open_image_in;
   rect_type              open_scissor_ff, open_scissor_in;
   logic [CNT_BITS-1:0]   open_start_ff, open_start_in;
   logic [CNT_BITS-1:0]   open_count_ff, open_count_in;
   logic [CNT_BITS-1:0]   total_ff, total_in;

   // Scissor the command sees once a pending frame start is applied.
   rect_type cur_base;

   // Results of one command.
   logic      close_vld, flush_vld;
   batch_type close_batch, flush_batch;

   // Result queue.
   batch_type              fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_BITS-1:0] fifo_cnt_ff;
   logic                   fifo_pop;
   logic [1:0]             fifo_push_n;
   batch_type              fifo_head;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff.xmin   <= VIEW_XMIN_RST;
         view_ff.ymin   <= VIEW_YMIN_RST;
         view_ff.xmax   <= VIEW_XMAX_RST;
         view_ff.ymax   <= VIEW_YMAX_RST;
         white_image_ff <= WHITE_IMAGE_RST;
         font_image_ff  <= FONT_IMAGE_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_VIEW_XMIN:   view_ff.xmin   <= csr_wdata[COORD_BITS-1:0];
            REG_VIEW_YMIN:   view_ff.ymin   <= csr_wdata[COORD_BITS-1:0];
            REG_VIEW_XMAX:   view_ff.xmax   <= csr_wdata[COORD_BITS-1:0];
            REG_VIEW_YMAX:   view_ff.ymax   <= csr_wdata[COORD_BITS-1:0];
            REG_WHITE_IMAGE: white_image_ff <= csr_wdata[IMAGE_BITS-1:0];
            REG_FONT_IMAGE:  font_image_ff  <= csr_wdata[IMAGE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Input side: the stage takes a new command whenever it retires or is empty.
   assign s2_fire   = s2_valid_ff && (fifo_cnt_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
   assign req_stall = s2_valid_ff && !s2_fire;
   assign accept    = req_valid && !req_stall;

   // Decide the stack access and the next level for the incoming command.
   always_comb begin
      logic [LEVEL_BITS-1:0] level_dec;
      logic                  push;
      logic                  pop_ok;

      level_dec = level_ff - LEVEL_BITS'(1);
      rd_addr   = level_dec[ADDR_BITS-1:0];
      push      = (req_type == CMD_CLIP_START) && (level_ff < LEVEL_BITS'(STACK_DEPTH));
      pop_ok    = (req_type == CMD_CLIP_END) && (level_ff != '0);

      level_in = level_ff;
      if (accept) begin
         if (req_frame_end) begin
            level_in = '0;
         end else if (push) begin
            level_in = level_ff + LEVEL_BITS'(1);
         end else if (pop_ok) begin
            level_in = level_dec;
         end else if (req_type == CMD_CLIP_END) begin
            level_in = '0;
         end
      end

      s2_in.cmd             = req_type;
      s2_in.box_x           = req_box_x;
      s2_in.box_y           = req_box_y;
      s2_in.box_w           = req_box_w;
      s2_in.box_h           = req_box_h;
      s2_in.clip_horizontal = req_clip_horizontal;
      s2_in.clip_vertical   = req_clip_vertical;
      s2_in.has_image       = req_has_image;
      s2_in.image_id        = req_image_id;
      s2_in.image_valid     = req_image_valid;
      s2_in.index_count     = req_index_count;
      s2_in.frame_end       = req_frame_end;
      s2_in.push            = push;
      s2_in.pop_ok          = pop_ok;
      s2_in.addr            = push ? level_ff[ADDR_BITS-1:0] : rd_addr;

      s2_valid_in = accept ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         level_ff    <= level_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_ff <= s2_in;
      end
   end

   // Stack memory: push writes the old scissor; the read for a pop is taken at accept,
   // with the data of a same-cycle push to the same entry forwarded.
   always_ff @(posedge clock) begin
      if (s2_fire && s2_ff.push) begin
         stack_mem[s2_ff.addr] <= cur_base;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (s2_fire && s2_ff.push && (s2_ff.addr == rd_addr)) begin
            rd_data_ff <= cur_base;
         end else begin
            rd_data_ff <= stack_mem[rd_addr];
         end
      end
   end

   // Command processing: scissor update, batch break and frame flush.
   always_comb begin
      logic signed [COORD_BITS:0] bx_e, by_e, bxr_e, byr_e;
      logic signed [COORD_BITS:0] cxmin_e, cymin_e, cxmax_e, cymax_e;
      rect_type                   clip_r;
      logic [CNT_BITS-1:0]        total_base;
      logic                       draw;
      logic [IMAGE_BITS-1:0]      image;
      logic                       match;
      logic [CNT_BITS:0]          cnt_sum, tot_sum;
      logic [CNT_BITS-1:0]        cnt_sat, tot_sat;

      cur_base   = fresh_ff ? view_ff : cur_ff;
      total_base = fresh_ff ? '0 : total_ff;

      // Intersection with the command box, one extra bit for the far edges.
      bx_e    = (COORD_BITS + 1)'($signed(s2_ff.box_x));
      by_e    = (COORD_BITS + 1)'($signed(s2_ff.box_y));
      bxr_e   = bx_e + $signed({2'b00, s2_ff.box_w});
      byr_e   = by_e + $signed({2'b00, s2_ff.box_h});
      cxmin_e = (COORD_BITS + 1)'($signed(cur_base.xmin));
      cymin_e = (COORD_BITS + 1)'($signed(cur_base.ymin));
      cxmax_e = (COORD_BITS + 1)'($signed(cur_base.xmax));
      cymax_e = (COORD_BITS + 1)'($signed(cur_base.ymax));
      clip_r  = cur_base;
      if (s2_ff.clip_horizontal) begin
         if (bx_e > cxmin_e) clip_r.xmin = s2_ff.box_x;
         if (bxr_e < cxmax_e) clip_r.xmax = bxr_e[COORD_BITS-1:0];
      end
      if (s2_ff.clip_vertical) begin
         if (by_e > cymin_e) clip_r.ymin = s2_ff.box_y;
         if (byr_e < cymax_e) clip_r.ymax = byr_e[COORD_BITS-1:0];
      end
      if (clip_r.xmax < clip_r.xmin) clip_r.xmax = clip_r.xmin;
      if (clip_r.ymax < clip_r.ymin) clip_r.ymax = clip_r.ymin;

      draw   = 1'b0;
      image  = white_image_ff;
      cur_in = cur_base;
      case (s2_ff.cmd)
         CMD_TEXT: begin
            draw  = 1'b1;
            image = font_image_ff;
         end
         CMD_RECT: begin
            draw = 1'b1;
         end
         CMD_IMAGE: begin
            draw  = !(s2_ff.has_image && !s2_ff.image_valid);
            image = s2_ff.has_image ? s2_ff.image_id : white_image_ff;
         end
         CMD_CLIP_START: begin
            cur_in = clip_r;
         end
         CMD_CLIP_END: begin
            cur_in = s2_ff.pop_ok ? rd_data_ff : view_ff;
         end
         default: ;
      endcase
      draw = draw && (s2_ff.index_count != '0);

      // Saturating index counters.
      cnt_sum = {1'b0, open_count_ff} + {{(CNT_BITS + 1 - COUNT_BITS){1'b0}}, s2_ff.index_count};
      tot_sum = {1'b0, total_base} + {{(CNT_BITS + 1 - COUNT_BITS){1'b0}}, s2_ff.index_count};
      cnt_sat = cnt_sum[CNT_BITS] ? CNT_MAX : cnt_sum[CNT_BITS-1:0];
      tot_sat = tot_sum[CNT_BITS] ? CNT_MAX : tot_sum[CNT_BITS-1:0];

      match = open_valid_ff && (open_type_ff == s2_ff.cmd[1:0]) &&
              (open_image_ff == image) && (open_scissor_ff == cur_base);

      close_batch.start_index   = open_start_ff;
      close_batch.num_indices   = open_count_ff;
      close_batch.text_pipeline = (open_type_ff == 2'(CMD_TEXT));
      close_batch.batch_image   = open_image_ff;
      close_batch.scissor       = open_scissor_ff;
      close_batch.frame_last    = 1'b0;
      close_vld                 = draw && !match && open_valid_ff;

      open_valid_in   = open_valid_ff;
      open_type_in    = open_type_ff;
      open_image_in   = open_image_ff;
      open_scissor_in = open_scissor_ff;
      open_start_in   = open_start_ff;
      open_count_in   = open_count_ff;
      total_in        = total_base;
      if (draw) begin
         if (match) begin
            open_count_in = cnt_sat;
         end else begin
            open_valid_in   = 1'b1;
            open_type_in    = s2_ff.cmd[1:0];
            open_image_in   = image;
            open_scissor_in = cur_base;
            open_start_in   = total_base;
            open_count_in   = {{(CNT_BITS - COUNT_BITS){1'b0}}, s2_ff.index_count};
         end
         total_in = tot_sat;
      end

      // Frame end flushes whatever batch is open after this command.
      flush_batch.start_index   = open_start_in;
      flush_batch.num_indices   = open_count_in;
      flush_batch.text_pipeline = (open_type_in == 2'(CMD_TEXT));
      flush_batch.batch_image   = open_image_in;
      flush_batch.scissor       = open_scissor_in;
      flush_batch.frame_last    = 1'b1;
      flush_vld                 = s2_ff.frame_end && open_valid_in;

      fresh_in = 1'b0;
      if (s2_ff.frame_end) begin
         open_valid_in = 1'b0;
         fresh_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff          <= {VIEW_XMIN_RST, VIEW_YMIN_RST, VIEW_XMAX_RST, VIEW_YMAX_RST};
         fresh_ff        <= 1'b1;
         open_valid_ff   <= 1'b0;
         open_type_ff    <= '0;
         open_image_ff   <= '0;
         open_scissor_ff <= {VIEW_XMIN_RST, VIEW_YMIN_RST, VIEW_XMAX_RST, VIEW_YMAX_RST};
         open_start_ff   <= '0;
         open_count_ff   <= '0;
         total_ff        <= '0;
      end else if (s2_fire) begin
         cur_ff          <= cur_in;
         fresh_ff        <= fresh_in;
         open_valid_ff   <= open_valid_in;
         open_type_ff    <= open_type_in;
         open_image_ff   <= open_image_in;
         open_scissor_ff <= open_scissor_in;
         open_start_ff   <= open_start_in;
         open_count_ff   <= open_count_in;
         total_ff        <= total_in;
      end
   end

   // Result queue: up to two batches in per command, one out per cycle while rsp_stall is low.
   assign fifo_pop    = rsp_valid && !rsp_stall;
   assign fifo_push_n = s2_fire ? ({1'b0, close_vld} + {1'b0, flush_vld}) : 2'd0;

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         if (close_vld) begin
            fifo_ff[wr_ptr_ff] <= close_batch;
            if (flush_vld) begin
               fifo_ff[wr_ptr_ff + FIFO_PTR_BITS'(1)] <= flush_batch;
            end
         end else if (flush_vld) begin
            fifo_ff[wr_ptr_ff] <= flush_batch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_ff + FIFO_PTR_BITS'(fifo_push_n);
         rd_ptr_ff   <= rd_ptr_ff + FIFO_PTR_BITS'(fifo_pop);
         fifo_cnt_ff <= fifo_cnt_ff + FIFO_CNT_BITS'(fifo_push_n) - FIFO_CNT_BITS'(fifo_pop);
      end
   end

   // Output drive from the queue head.
   assign fifo_head         = fifo_ff[rd_ptr_ff];
   assign rsp_valid         = (fifo_cnt_ff != '0);
   assign rsp_start_index   = fifo_head.start_index;
   assign rsp_num_indices   = fifo_head.num_indices;
   assign rsp_text_pipeline = fifo_head.text_pipeline;
   assign rsp_batch_image   = fifo_head.batch_image;
   assign rsp_sc_xmin       = fifo_head.scissor.xmin;
   assign rsp_sc_ymin       = fifo_head.scissor.ymin;
   assign rsp_sc_xmax       = fifo_head.scissor.xmax;
   assign rsp_sc_ymax       = fifo_head.scissor.ymax;
   assign rsp_frame_last    = fifo_head.frame_last;

endmodule

`default_nettype wire

// ----- test/clip_batch_checker.sv -----
`default_nettype none

// Watches the command, batch and register ports of the clip stack batcher, keeps its own
// copy of the scissor stack and the open batch, and compares every batch that leaves the
// block with the oldest predicted one.
module clip_batch_checker (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write,
   input  wire logic [csdb_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire logic [csdb_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  wire logic                                   req_valid,
   input  wire logic                                   req_stall,
   input  wire logic [csdb_pkg::TYPE_BITS-1:0]         req_type,
   input  wire logic signed [csdb_pkg::COORD_BITS-1:0] req_box_x,
   input  wire logic signed [csdb_pkg::COORD_BITS-1:0] req_box_y,
   input  wire logic [csdb_pkg::SIZE_BITS-1:0]         req_box_w,
   input  wire logic [csdb_pkg::SIZE_BITS-1:0]         req_box_h,
   input  wire logic                                   req_clip_horizontal,
   input  wire logic                                   req_clip_vertical,
   input  wire logic                                   req_has_image,
   input  wire logic [csdb_pkg::IMAGE_BITS-1:0]        req_image_id,
   input  wire logic                                   req_image_valid,
   input  wire logic [csdb_pkg::COUNT_BITS-1:0]        req_index_count,
   input  wire logic                                   req_frame_end,
   input  wire logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   input  wire logic [csdb_pkg::CNT_BITS-1:0]          rsp_start_index,
   input  wire logic [csdb_pkg::CNT_BITS-1:0]          rsp_num_indices,
   input  wire logic                                   rsp_text_pipeline,
   input  wire logic [csdb_pkg::IMAGE_BITS-1:0]        rsp_batch_image,
   input  wire logic signed [csdb_pkg::COORD_BITS-1:0] rsp_sc_xmin,
   input  wire logic signed [csdb_pkg::COORD_BITS-1:0] rsp_sc_ymin,
   input  wire logic signed [csdb_pkg::COORD_BITS-1:0] rsp_sc_xmax,
   input  wire logic signed [csdb_pkg::COORD_BITS-1:0] rsp_sc_ymax,
   input  wire logic                                   rsp_frame_last,
   output int                                          mismatch_count,
   output int                                          batches_pending
);
   import csdb_pkg::*;

   // Register copies.
   rect_type              viewport;
   logic [IMAGE_BITS-1:0] white_image;
   logic [IMAGE_BITS-1:0] font_image;

   // Clip stack and the scissor in force.
   rect_type              saved_scissor [STACK_DEPTH];
   int                    clip_depth;
   rect_type              scissor;
   logic                  new_frame;
   logic [CNT_BITS-1:0]   frame_total;

   // The batch that is still growing.
   logic                  batch_open;
   logic [TYPE_BITS-1:0]  batch_kind;
   logic [IMAGE_BITS-1:0] batch_img;
   rect_type              batch_scissor;
   logic [CNT_BITS-1:0]   batch_start;
   logic [CNT_BITS-1:0]   batch_count;

   batch_type             predicted_batches [$];
   int                    mismatches;

   function automatic logic [CNT_BITS-1:0] add_saturating(logic [CNT_BITS-1:0] total,
                                                          logic [COUNT_BITS-1:0] amount);
      logic [CNT_BITS:0] sum;
      sum = {1'b0, total} + {{(CNT_BITS + 1 - COUNT_BITS){1'b0}}, amount};
      return sum[CNT_BITS] ? CNT_MAX : sum[CNT_BITS-1:0];
   endfunction

   // Queue the open batch as the next batch the block has to deliver.
   task automatic close_batch(input logic last);
      batch_type b;
      b.start_index   = batch_start;
      b.num_indices   = batch_count;
      b.text_pipeline = (batch_kind == CMD_TEXT);
      b.batch_image   = batch_img;
      b.scissor       = batch_scissor;
      b.frame_last    = last;
      predicted_batches.push_back(b);
   endtask

   // Apply one accepted command to the predicted state.
   task automatic predict_command();
      rect_type              r;
      int                    reach;
      logic                  draws;
      logic [IMAGE_BITS-1:0] img;
      draws = 1'b0;
      img   = '0;
      if (new_frame) begin
         scissor     = viewport;
         clip_depth  = 0;
         frame_total = '0;
         new_frame   = 1'b0;
      end
      case (req_type)
         CMD_TEXT: begin
            draws = 1'b1;
            img   = font_image;
         end
         CMD_RECT: begin
            draws = 1'b1;
            img   = white_image;
         end
         CMD_IMAGE: begin
            draws = !(req_has_image && !req_image_valid);
            img   = req_has_image ? req_image_id : white_image;
         end
         CMD_CLIP_START: begin
            // Intersect on the selected axes, then collapse an inverted result.
            r = scissor;
            if (req_clip_horizontal) begin
               if ($signed(req_box_x) > $signed(r.xmin)) r.xmin = req_box_x;
               reach = int'($signed(req_box_x)) + int'(req_box_w);
               if (reach < int'($signed(r.xmax))) r.xmax = COORD_BITS'(reach);
            end
            if (req_clip_vertical) begin
               if ($signed(req_box_y) > $signed(r.ymin)) r.ymin = req_box_y;
               reach = int'($signed(req_box_y)) + int'(req_box_h);
               if (reach < int'($signed(r.ymax))) r.ymax = COORD_BITS'(reach);
            end
            if ($signed(r.xmax) < $signed(r.xmin)) r.xmax = r.xmin;
            if ($signed(r.ymax) < $signed(r.ymin)) r.ymax = r.ymin;
            // A full stack drops the save but still narrows.
            if (clip_depth < STACK_DEPTH) begin
               saved_scissor[clip_depth] = scissor;
               clip_depth++;
            end
            scissor = r;
         end
         CMD_CLIP_END: begin
            if (clip_depth > 0) begin
               clip_depth--;
               scissor = saved_scissor[clip_depth];
            end else begin
               scissor = viewport;
            end
         end
         default: ;
      endcase

      // Extend the open batch or close it and start a new one.
      if (draws && req_index_count != '0) begin
         if (batch_open && batch_kind == req_type && batch_img == img &&
             batch_scissor == scissor) begin
            batch_count = add_saturating(batch_count, req_index_count);
         end else begin
            if (batch_open) close_batch(1'b0);
            batch_open    = 1'b1;
            batch_kind    = req_type;
            batch_img     = img;
            batch_scissor = scissor;
            batch_start   = frame_total;
            batch_count   = CNT_BITS'(req_index_count);
         end
         frame_total = add_saturating(frame_total, req_index_count);
      end

      if (req_frame_end) begin
         if (batch_open) begin
            close_batch(1'b1);
            batch_open = 1'b0;
         end
         new_frame = 1'b1;
      end
   endtask

   function automatic int field_differs(string name, logic [CNT_BITS-1:0] want,
                                        logic [CNT_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: batch field %s mismatch, expected %h, actual %h",
                  $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      batch_type want;
      if (reset) begin
         viewport      = '{VIEW_XMIN_RST, VIEW_YMIN_RST, VIEW_XMAX_RST, VIEW_YMAX_RST};
         white_image   = WHITE_IMAGE_RST;
         font_image    = FONT_IMAGE_RST;
         clip_depth    = 0;
         scissor       = viewport;
         new_frame     = 1'b1;
         frame_total   = '0;
         batch_open    = 1'b0;
         batch_kind    = CMD_TEXT;
         batch_img     = '0;
         batch_scissor = viewport;
         batch_start   = '0;
         batch_count   = '0;
         predicted_batches.delete();
      end else begin
         // Register writes.
         if (csr_write) begin
            case (csr_index)
               REG_VIEW_XMIN:   viewport.xmin = csr_wdata;
               REG_VIEW_YMIN:   viewport.ymin = csr_wdata;
               REG_VIEW_XMAX:   viewport.xmax = csr_wdata;
               REG_VIEW_YMAX:   viewport.ymax = csr_wdata;
               REG_WHITE_IMAGE: white_image   = csr_wdata;
               REG_FONT_IMAGE:  font_image    = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && !req_stall) predict_command();

         // Each delivered batch against the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (predicted_batches.size() == 0) begin
               $display("%0t: batch delivered with none predicted, start %h count %h",
                        $time, rsp_start_index, rsp_num_indices);
               mismatches++;
            end else begin
               want = predicted_batches.pop_front();
               mismatches += field_differs("start_index", want.start_index, rsp_start_index);
               mismatches += field_differs("num_indices", want.num_indices, rsp_num_indices);
               mismatches += field_differs("text_pipeline", CNT_BITS'(want.text_pipeline),
                                           CNT_BITS'(rsp_text_pipeline));
               mismatches += field_differs("batch_image", CNT_BITS'(want.batch_image),
                                           CNT_BITS'(rsp_batch_image));
               mismatches += field_differs("sc_xmin", CNT_BITS'($unsigned(want.scissor.xmin)),
                                           CNT_BITS'($unsigned(rsp_sc_xmin)));
               mismatches += field_differs("sc_ymin", CNT_BITS'($unsigned(want.scissor.ymin)),
                                           CNT_BITS'($unsigned(rsp_sc_ymin)));
               mismatches += field_differs("sc_xmax", CNT_BITS'($unsigned(want.scissor.xmax)),
                                           CNT_BITS'($unsigned(rsp_sc_xmax)));
               mismatches += field_differs("sc_ymax", CNT_BITS'($unsigned(want.scissor.ymax)),
                                           CNT_BITS'($unsigned(rsp_sc_ymax)));
               mismatches += field_differs("frame_last", CNT_BITS'(want.frame_last),
                                           CNT_BITS'(rsp_frame_last));
            end
         end
      end
      mismatch_count  <= mismatches;
      batches_pending <= predicted_batches.size();
   end

endmodule

`default_nettype wire

// ----- test/clip_stack_draw_batcher_tb.sv -----
`default_nettype none

module clip_stack_draw_batcher_tb;
   import csdb_pkg::*;

   localparam int IDLE_PERCENT   = 27;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 4000;

   // Type codes the block must ignore.
   localparam logic [TYPE_BITS-1:0] CMD_UNKNOWN_LOW  = TYPE_BITS'(CMD_CLIP_END + 1);
   localparam logic [TYPE_BITS-1:0] CMD_UNKNOWN_HIGH = '1;

   typedef struct packed {
      logic [TYPE_BITS-1:0]         kind;
      logic signed [COORD_BITS-1:0] box_x;
      logic signed [COORD_BITS-1:0] box_y;
      logic [SIZE_BITS-1:0]         box_w;
      logic [SIZE_BITS-1:0]         box_h;
      logic                         clip_horizontal;
      logic                         clip_vertical;
      logic                         has_image;
      logic [IMAGE_BITS-1:0]        image_id;
      logic                         image_valid;
      logic [COUNT_BITS-1:0]        index_count;
      logic                         frame_end;
   } command_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0]      csr_index = '0;
   logic [CSR_DATA_BITS-1:0]     csr_wdata = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [TYPE_BITS-1:0]         req_type = '0;
   logic signed [COORD_BITS-1:0] req_box_x = '0;
   logic signed [COORD_BITS-1:0] req_box_y = '0;
   logic [SIZE_BITS-1:0]         req_box_w = '0;
   logic [SIZE_BITS-1:0]         req_box_h = '0;
   logic                         req_clip_horizontal = 1'b0;
   logic                         req_clip_vertical = 1'b0;
   logic                         req_has_image = 1'b0;
   logic [IMAGE_BITS-1:0]        req_image_id = '0;
   logic                         req_image_valid = 1'b0;
   logic [COUNT_BITS-1:0]        req_index_count = '0;
   logic                         req_frame_end = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b1;
   logic [CNT_BITS-1:0]          rsp_start_index;
   logic [CNT_BITS-1:0]          rsp_num_indices;
   logic                         rsp_text_pipeline;
   logic [IMAGE_BITS-1:0]        rsp_batch_image;
   logic signed [COORD_BITS-1:0] rsp_sc_xmin;
   logic signed [COORD_BITS-1:0] rsp_sc_ymin;
   logic signed [COORD_BITS-1:0] rsp_sc_xmax;
   logic signed [COORD_BITS-1:0] rsp_sc_ymax;
   logic                         rsp_frame_last;
   int                           mismatch_count;
   int                           batches_pending;

   // Steady pacing for the command sender and the batch receiver, and the receiver's hold request.
   logic                         steady = 1'b0;
   logic                         hold_request = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   clip_stack_draw_batcher i_dut (.*);

   clip_batch_checker i_batch_checker (.*);

   // Command construction.
   function automatic command_type random_command();
      command_type c;
      c.kind            = TYPE_BITS'($urandom_range(0, 7));
      c.box_x           = COORD_BITS'($urandom);
      c.box_y           = COORD_BITS'($urandom);
      c.box_w           = SIZE_BITS'($urandom);
      c.box_h           = SIZE_BITS'($urandom);
      c.clip_horizontal = 1'($urandom_range(0, 1));
      c.clip_vertical   = 1'($urandom_range(0, 1));
      c.has_image       = 1'($urandom_range(0, 1));
      c.image_id        = IMAGE_BITS'($urandom);
      c.image_valid     = 1'($urandom_range(0, 1));
      c.index_count     = COUNT_BITS'($urandom);
      c.frame_end       = ($urandom_range(0, 7) == 0);
      return c;
   endfunction

   function automatic command_type make_cmd(logic [TYPE_BITS-1:0] kind,
                                            logic [COUNT_BITS-1:0] count, logic last);
      command_type c;
      c             = random_command();
      c.kind        = kind;
      c.index_count = count;
      c.frame_end   = last;
      return c;
   endfunction

   function automatic command_type make_box_clip(logic [COORD_BITS-1:0] x,
                                                 logic [COORD_BITS-1:0] y,
                                                 logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h,
                                                 logic horizontal, logic vertical);
      command_type c;
      c                 = make_cmd(CMD_CLIP_START, '0, 1'b0);
      c.box_x           = x;
      c.box_y           = y;
      c.box_w           = w;
      c.box_h           = h;
      c.clip_horizontal = horizontal;
      c.clip_vertical   = vertical;
      return c;
   endfunction

   function automatic logic [COUNT_BITS-1:0] random_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return '0;
      if (roll < 15) return COUNT_BITS'($urandom);
      return COUNT_BITS'($urandom_range(1, 300));
   endfunction

   // A drawing command with images picked from a small set, so batches often merge.
   function automatic command_type make_draw();
      command_type c;
      c = random_command();
      case ($urandom_range(0, 2))
         0:       c.kind = CMD_TEXT;
         1:       c.kind = CMD_RECT;
         default: c.kind = CMD_IMAGE;
      endcase
      c.has_image   = ($urandom_range(0, 3) != 0);
      c.image_valid = ($urandom_range(0, 9) != 0);
      c.image_id    = ($urandom_range(0, 9) == 0) ? IMAGE_BITS'($urandom)
                                                  : IMAGE_BITS'($urandom_range(0, 3));
      c.index_count = random_count();
      c.frame_end   = 1'b0;
      return c;
   endfunction

   // Mostly boxes near the usual screen area, sometimes anywhere.
   function automatic command_type make_clip();
      command_type c;
      c      = random_command();
      c.kind = CMD_CLIP_START;
      if ($urandom_range(0, 4) != 0) begin
         c.box_x = COORD_BITS'($urandom_range(0, 2200) - 100);
         c.box_y = COORD_BITS'($urandom_range(0, 1300) - 100);
         c.box_w = SIZE_BITS'($urandom_range(0, 2000));
         c.box_h = SIZE_BITS'($urandom_range(0, 1200));
      end
      c.frame_end = 1'b0;
      return c;
   endfunction

   // Offer one command and hold it until the block takes the transaction.
   task automatic send_command(input command_type c);
      if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= c.kind;
      req_box_x           <= c.box_x;
      req_box_y           <= c.box_y;
      req_box_w           <= c.box_w;
      req_box_h           <= c.box_h;
      req_clip_horizontal <= c.clip_horizontal;
      req_clip_vertical   <= c.clip_vertical;
      req_has_image       <= c.has_image;
      req_image_id        <= c.image_id;
      req_image_valid     <= c.image_valid;
      req_index_count     <= c.index_count;
      req_frame_end       <= c.frame_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering and wait until every predicted batch has come out.
   task automatic finish_phase();
      req_valid <= 1'b0;
      do @(posedge clock); while (batches_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [CSR_DATA_BITS-1:0] xmin, ymin, xmax, ymax,
                                input logic [CSR_DATA_BITS-1:0] white, font);
      csr_write <= 1'b1;
      csr_index <= REG_VIEW_XMIN;
      csr_wdata <= xmin;
      @(posedge clock);
      csr_index <= REG_VIEW_YMIN;
      csr_wdata <= ymin;
      @(posedge clock);
      csr_index <= REG_VIEW_XMAX;
      csr_wdata <= xmax;
      @(posedge clock);
      csr_index <= REG_VIEW_YMAX;
      csr_wdata <= ymax;
      @(posedge clock);
      csr_index <= REG_WHITE_IMAGE;
      csr_wdata <= white;
      @(posedge clock);
      csr_index <= REG_FONT_IMAGE;
      csr_wdata <= font;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Hand-picked commands under the reset settings.
   task automatic run_directed();
      command_type c;
      // Merge, skip on zero count, break on type change.
      send_command(make_cmd(CMD_TEXT, COUNT_BITS'(1), 1'b0));
      send_command(make_cmd(CMD_TEXT, '1, 1'b0));
      send_command(make_cmd(CMD_RECT, '0, 1'b0));
      send_command(make_cmd(CMD_RECT, COUNT_BITS'(10), 1'b0));
      // Invalid image is skipped; named image, then the white image.
      c             = make_cmd(CMD_IMAGE, COUNT_BITS'(5), 1'b0);
      c.has_image   = 1'b1;
      c.image_valid = 1'b0;
      send_command(c);
      c.image_valid = 1'b1;
      c.image_id    = '1;
      send_command(c);
      c.has_image   = 1'b0;
      c.index_count = COUNT_BITS'(3);
      send_command(c);
      // Clip that comes out inverted on both axes.
      send_command(make_box_clip(16'h8000, 16'h8000, '1, '1, 1'b1, 1'b1));
      send_command(make_cmd(CMD_RECT, COUNT_BITS'(7), 1'b0));
      send_command(make_cmd(CMD_CLIP_END, '0, 1'b0));
      send_command(make_box_clip(16'h7FFF, '0, '1, '0, 1'b1, 1'b0));
      send_command(make_cmd(CMD_CLIP_END, '0, 1'b0));
      send_command(make_box_clip('0, COORD_BITS'(100), '0, SIZE_BITS'(200), 1'b0, 1'b1));
      send_command(make_box_clip('1, '1, '1, '1, 1'b0, 1'b0));
      // Close and flush in one command, then frame ends with nothing open.
      send_command(make_cmd(CMD_TEXT, COUNT_BITS'(4), 1'b1));
      send_command(make_cmd(CMD_UNKNOWN_LOW, COUNT_BITS'(9), 1'b1));
      send_command(make_cmd(CMD_UNKNOWN_HIGH, COUNT_BITS'(9), 1'b0));
      // Clip end on an empty stack falls back to the viewport.
      send_command(make_cmd(CMD_CLIP_END, '0, 1'b0));
      send_command(make_cmd(CMD_TEXT, COUNT_BITS'(2), 1'b0));
      // One push more than the stack holds.
      for (int i = 0; i <= STACK_DEPTH; i++) begin
         send_command(make_box_clip(COORD_BITS'(10 * i), COORD_BITS'(5 * i),
                                    SIZE_BITS'(1000), SIZE_BITS'(800), 1'b1, 1'b1));
      end
      send_command(make_cmd(CMD_RECT, COUNT_BITS'(8), 1'b0));
      send_command(make_cmd(CMD_CLIP_END, '0, 1'b1));
   endtask

   // Frames of nested clips and draws, with some noise mixed in.
   task automatic run_frames(input int items);
      command_type c;
      command_type last_draw;
      int          sent;
      int          depth;
      int          frame_len;
      int          roll;
      sent      = 0;
      depth     = 0;
      last_draw = make_draw();
      while (sent < items) begin
         frame_len = $urandom_range(1, 24);
         for (int i = 0; i < frame_len && sent < items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               c = random_command();
            end else if (roll < 22 && depth <= STACK_DEPTH) begin
               c = make_clip();
            end else if (roll < 34 && depth > 0) begin
               c = make_cmd(CMD_CLIP_END, '0, 1'b0);
            end else begin
               // Repeat the last draw often so that batches grow.
               if ($urandom_range(0, 99) < 60) begin
                  c             = last_draw;
                  c.index_count = random_count();
               end else begin
                  c = make_draw();
               end
               last_draw = c;
            end
            if (roll >= 8) c.frame_end = (i == frame_len - 1) || ($urandom_range(0, 49) == 0);
            send_command(c);
            sent++;
            if (c.frame_end) depth = 0;
            else if (c.kind == CMD_CLIP_START) depth++;
            else if (c.kind == CMD_CLIP_END && depth > 0) depth--;
         end
      end
   endtask

   // Large counts in one frame, so that both the frame total and one batch saturate.
   task automatic run_saturation(input int items);
      command_type c;
      for (int i = 0; i < items; i++) begin
         c = make_cmd((i >= items - 10 && i % 2 == 1) ? CMD_RECT : CMD_TEXT,
                      COUNT_BITS'($urandom_range(60000, 65535)), (i == items - 1));
         send_command(c);
      end
   endtask

   // Batch receiver: random stalls, one long hold-off on request.
   initial begin
      logic hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (steady || $urandom_range(0, 99) >= IDLE_PERCENT) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transaction.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("clip_stack_draw_batcher test failed");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      finish_phase();

      // Widest viewport, image registers at opposite extremes; long hold-off here.
      load_settings(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0000);
      hold_request = 1'b1;
      run_frames(190);
      finish_phase();

      // Small viewport and images that collide with command images; no idling.
      load_settings(CSR_DATA_BITS'($urandom_range(0, 50)), CSR_DATA_BITS'($urandom_range(0, 50)),
                    CSR_DATA_BITS'($urandom_range(800, 1920)),
                    CSR_DATA_BITS'($urandom_range(400, 1080)),
                    CSR_DATA_BITS'($urandom_range(0, 3)), CSR_DATA_BITS'($urandom_range(0, 3)));
      steady = 1'b1;
      run_frames(190);
      finish_phase();
      steady = 1'b0;

      // Inverted viewport, white and font images equal.
      load_settings(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0002, 16'h0002);
      run_frames(190);
      finish_phase();

      // Arbitrary register values.
      load_settings(CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                    CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                    CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom));
      run_frames(190);
      finish_phase();

      load_settings(16'hFFFB, 16'hFFFB, 16'h0064, 16'h0064, 16'h1234, 16'h00FF);
      run_saturation(290);
      finish_phase();

      if (mismatch_count == 0 && batches_pending == 0) begin
         $display("clip_stack_draw_batcher test passed");
      end else begin
         $display("clip_stack_draw_batcher test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
